// ===== rtl/core/vtp_pkg.sv =====
`timescale 1ns / 1ps
package vtp_pkg;

	localparam int unsigned CoefW  = 16;
	localparam int unsigned PosW   = 32;
	localparam int unsigned ColorW = 16;
	localparam int unsigned CfgIdxW = 8;
	localparam int unsigned RowW   = 64;
	// numerator of the divide is x << 16, up to 48 magnitude bits
	localparam int unsigned NumW   = 48;

	localparam logic [RowW-1:0] ROW0_RST = 64'h0000_0000_0000_0100;
	localparam logic [RowW-1:0] ROW1_RST = 64'h0000_0000_0100_0000;
	localparam logic [RowW-1:0] ROW2_RST = 64'h0000_0100_0000_0000;
	localparam logic [RowW-1:0] ROW3_RST = 64'h0100_0000_0000_0000;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_ROW0 = 8'd0,
		CFG_ROW1 = 8'd1,
		CFG_ROW2 = 8'd2,
		CFG_ROW3 = 8'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [PosW-1:0]   pos_x;
		logic signed [PosW-1:0]   pos_y;
		logic signed [PosW-1:0]   pos_z;
		logic        [ColorW-1:0] color_red;
		logic        [ColorW-1:0] color_green;
		logic        [ColorW-1:0] color_blue;
	} vtx_in_t;

	typedef struct packed {
		logic signed [PosW-1:0]   out_x;
		logic signed [PosW-1:0]   out_y;
		logic signed [PosW-1:0]   out_z;
		logic signed [PosW-1:0]   out_w;
		logic        [ColorW-1:0] out_red;
		logic        [ColorW-1:0] out_green;
		logic        [ColorW-1:0] out_blue;
		logic                     divide_fault;
	} vtx_out_t;

	// matrix stage result handed to the divider
	typedef struct packed {
		logic signed [PosW-1:0]   tx;
		logic signed [PosW-1:0]   ty;
		logic signed [PosW-1:0]   tz;
		logic signed [PosW-1:0]   tw;
		logic        [ColorW-1:0] red;
		logic        [ColorW-1:0] green;
		logic        [ColorW-1:0] blue;
	} xform_t;

	// fields that ride along the divider stages
	typedef struct packed {
		logic signed [PosW-1:0]   tz;
		logic signed [PosW-1:0]   tw;
		logic        [ColorW-1:0] red;
		logic        [ColorW-1:0] green;
		logic        [ColorW-1:0] blue;
		logic                     fault;
		logic                     neg_x;
		logic                     neg_y;
		logic        [PosW-1:0]   dvs;
	} div_side_t;

endpackage

// ===== rtl/core/vertex_transform_perspective_top.sv =====
`timescale 1ns / 1ps
// Vertex transform with perspective divide.
// Input channel (in_valid / in_stall / in_data): one vertex per beat, a Q16.16
// position and a color. Output channel (out_valid / out_stall / out_data):
// the transformed, divided position, z and w, the color and a fault bit that
// flags a zero transformed z (x and y then read 0).
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): one 64-bit
// matrix row per beat, index 0..3; other indexes are ignored. cfg_ready is
// always high. Write only while the pipe is empty.
// Pipeline from input beat to output beat: 3 matrix stages, 1 divider
// setup stage, 48 one-bit divide stages, 1 output register.
// Throughput: one vertex per cycle while out_stall does not hold the pipe;
// the 48-stage restoring divider sets the depth.
// Reset clears every valid bit and loads the identity matrix.
// The whole pipe advances as a unit: when out_valid is high and out_stall is
// high, everything holds and in_stall goes high in the same cycle.
module vertex_transform_perspective_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  vtp_pkg::vtx_in_t                     in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output vtp_pkg::vtx_out_t                    out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [vtp_pkg::CfgIdxW-1:0]          cfg_index,
	input  logic [vtp_pkg::RowW-1:0]             cfg_data
);
	import vtp_pkg::*;

	logic [3:0][RowW-1:0] row_q;
	logic                 adv;
	logic                 mat_v;
	xform_t               mat_xf;

	assign adv       = !(out_valid && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW0_RST;
			row_q[1] <= ROW1_RST;
			row_q[2] <= ROW2_RST;
			row_q[3] <= ROW3_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROW0: row_q[0] <= cfg_data;
				CFG_ROW1: row_q[1] <= cfg_data;
				CFG_ROW2: row_q[2] <= cfg_data;
				CFG_ROW3: row_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	vtp_mat u_mat (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.in_v  (in_valid),
		.vin   (in_data),
		.rows  (row_q),
		.out_v (mat_v),
		.xf    (mat_xf)
	);

	vtp_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.in_v  (mat_v),
		.xf    (mat_xf),
		.out_v (out_valid),
		.res   (out_data)
	);

	a_fault_zero_xy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_fault |-> out_data.out_x == '0 && out_data.out_y == '0)
		else $error("fault beat with nonzero x/y");

	a_fault_matches_z: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.divide_fault == (out_data.out_z == '0))
		else $error("fault flag disagrees with z");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat lost under stall");

endmodule

// ===== rtl/core/vtp_mat.sv =====
`timescale 1ns / 1ps
module vtp_mat (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    adv,
	input  logic                                    in_v,
	input  vtp_pkg::vtx_in_t                        vin,
	input  logic [3:0][vtp_pkg::RowW-1:0]           rows,
	output logic                                    out_v,
	output vtp_pkg::xform_t                         xf
);
	import vtp_pkg::*;

	localparam int unsigned ProdW = CoefW + PosW;
	localparam int unsigned AccW  = ProdW + 3;

	logic                      v_s1, v_s2, v_s3;
	logic signed [ProdW-1:0]   prod_s1 [4][3];
	logic signed [CoefW-1:0]   c3_s1 [4];
	logic        [ColorW-1:0]  red_s1, green_s1, blue_s1;
	logic signed [AccW-1:0]    acc_s2 [4];
	logic        [ColorW-1:0]  red_s2, green_s2, blue_s2;
	logic signed [PosW-1:0]    res_s3 [4];
	logic        [ColorW-1:0]  red_s3, green_s3, blue_s3;
	logic signed [PosW-1:0]    vec [3];

	function automatic logic signed [PosW-1:0] round_sat(input logic signed [AccW-1:0] a);
		logic signed [AccW-1:0] r;
		r = (a + AccW'(128)) >>> 8;
		if (r > $signed(AccW'(32'h7fff_ffff)))
			return 32'sh7fff_ffff;
		else if (r < -$signed(AccW'(33'h0_8000_0000)))
			return 32'sh8000_0000;
		else
			return r[PosW-1:0];
	endfunction

	assign vec[0] = vin.pos_x;
	assign vec[1] = vin.pos_y;
	assign vec[2] = vin.pos_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 3; c++)
					prod_s1[r][c] <= $signed(rows[r][CoefW*c +: CoefW]) * vec[c];
				c3_s1[r] <= $signed(rows[r][CoefW*3 +: CoefW]);
			end
			red_s1   <= vin.color_red;
			green_s1 <= vin.color_green;
			blue_s1  <= vin.color_blue;

			// w is 1.0 (Q16.16), so column 3 adds its coefficient times 2^16
			for (int r = 0; r < 4; r++)
				acc_s2[r] <= AccW'(prod_s1[r][0]) + AccW'(prod_s1[r][1])
					+ AccW'(prod_s1[r][2]) + AccW'($signed({c3_s1[r], 16'h0}));
			red_s2   <= red_s1;
			green_s2 <= green_s1;
			blue_s2  <= blue_s1;

			for (int r = 0; r < 4; r++)
				res_s3[r] <= round_sat(acc_s2[r]);
			red_s3   <= red_s2;
			green_s3 <= green_s2;
			blue_s3  <= blue_s2;
		end
	end

	assign out_v    = v_s3;
	assign xf.tx    = res_s3[0];
	assign xf.ty    = res_s3[1];
	assign xf.tz    = res_s3[2];
	assign xf.tw    = res_s3[3];
	assign xf.red   = red_s3;
	assign xf.green = green_s3;
	assign xf.blue  = blue_s3;

endmodule

// ===== rtl/core/vtp_div.sv =====
`timescale 1ns / 1ps
module vtp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_v,
	input  vtp_pkg::xform_t   xf,
	output logic              out_v,
	output vtp_pkg::vtx_out_t res
);
	import vtp_pkg::*;

	logic                  v_s [NumW+1];
	logic [PosW-1:0]       rem_x_s [NumW+1];
	logic [PosW-1:0]       rem_y_s [NumW+1];
	logic [NumW-1:0]       wk_x_s [NumW+1];
	logic [NumW-1:0]       wk_y_s [NumW+1];
	div_side_t             side_s [NumW+1];
	vtx_out_t              res_q;
	logic                  res_v_q;
	div_side_t             side_in;
	logic [PosW-1:0]       mag_x, mag_y;
	logic [PosW:0]         tr_x [NumW];
	logic [PosW:0]         tr_y [NumW];
	logic                  ge_x [NumW];
	logic                  ge_y [NumW];

	function automatic logic [PosW-1:0] sat_q(input logic [NumW-1:0] q, input logic neg);
		if (neg) begin
			if (q > NumW'(33'h0_8000_0000))
				return 32'h8000_0000;
			else
				return -q[PosW-1:0];
		end else begin
			if (q > NumW'(32'h7fff_ffff))
				return 32'h7fff_ffff;
			else
				return q[PosW-1:0];
		end
	endfunction

	always_comb begin
		side_in.tz    = xf.tz;
		side_in.tw    = xf.tw;
		side_in.red   = xf.red;
		side_in.green = xf.green;
		side_in.blue  = xf.blue;
		side_in.fault = (xf.tz == '0);
		// divisor is -z; quotient sign flips when z > 0
		side_in.neg_x = xf.tx[PosW-1] ^ (!xf.tz[PosW-1] && !side_in.fault);
		side_in.neg_y = xf.ty[PosW-1] ^ (!xf.tz[PosW-1] && !side_in.fault);
		side_in.dvs   = side_in.fault ? PosW'(1)
			: (xf.tz[PosW-1] ? -xf.tz : xf.tz);
		mag_x = xf.tx[PosW-1] ? -xf.tx : xf.tx;
		mag_y = xf.ty[PosW-1] ? -xf.ty : xf.ty;
	end

	// restoring divide, one quotient bit per stage, MSB first
	always_comb begin
		for (int k = 0; k < NumW; k++) begin
			tr_x[k] = {rem_x_s[k], wk_x_s[k][NumW-1]};
			tr_y[k] = {rem_y_s[k], wk_y_s[k][NumW-1]};
			ge_x[k] = tr_x[k] >= {1'b0, side_s[k].dvs};
			ge_y[k] = tr_y[k] >= {1'b0, side_s[k].dvs};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NumW; k++)
				v_s[k] <= 1'b0;
			res_v_q <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_v;
			for (int k = 0; k < NumW; k++)
				v_s[k+1] <= v_s[k];
			res_v_q <= v_s[NumW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0]  <= side_in;
			rem_x_s[0] <= '0;
			rem_y_s[0] <= '0;
			wk_x_s[0]  <= {mag_x, 16'h0};
			wk_y_s[0]  <= {mag_y, 16'h0};
			for (int k = 0; k < NumW; k++) begin
				side_s[k+1]  <= side_s[k];
				rem_x_s[k+1] <= ge_x[k] ? PosW'(tr_x[k] - {1'b0, side_s[k].dvs})
					: tr_x[k][PosW-1:0];
				rem_y_s[k+1] <= ge_y[k] ? PosW'(tr_y[k] - {1'b0, side_s[k].dvs})
					: tr_y[k][PosW-1:0];
				wk_x_s[k+1]  <= {wk_x_s[k][NumW-2:0], ge_x[k]};
				wk_y_s[k+1]  <= {wk_y_s[k][NumW-2:0], ge_y[k]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.out_x <= side_s[NumW].fault ? '0 : sat_q(wk_x_s[NumW], side_s[NumW].neg_x);
			res_q.out_y <= side_s[NumW].fault ? '0 : sat_q(wk_y_s[NumW], side_s[NumW].neg_y);
			res_q.out_z        <= side_s[NumW].tz;
			res_q.out_w        <= side_s[NumW].tw;
			res_q.out_red      <= side_s[NumW].red;
			res_q.out_green    <= side_s[NumW].green;
			res_q.out_blue     <= side_s[NumW].blue;
			res_q.divide_fault <= side_s[NumW].fault;
		end
	end

	assign out_v = res_v_q;
	assign res   = res_q;

endmodule
